// ----- hdl/mau_pkg.sv -----
// Shared types and constants of the modular arithmetic unit.
package mau_pkg;

   localparam int FIELD_WIDTH = 64;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_SQR = 2'd3
   } cmd_type;

   // Strobes from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic prep;
      logic sub;
      logic reduce;
      logic mul;
      logic write_out;
   } dp_ctrl_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic last_bit;
   } dp_stat_type;

endpackage

// ----- hdl/mau_datapath.sv -----
// Datapath of the modular arithmetic unit: operand registers, reducer, adders.
module mau_datapath #(
   parameter int W = 64
) (
   input  logic                                     clock,
   input  mau_pkg::dp_ctrl_type                     ctrl,
   input  mau_pkg::cmd_type                         req_cmd,
   input  logic [mau_pkg::FIELD_WIDTH-1:0]          req_operand_a,
   input  logic [mau_pkg::FIELD_WIDTH-1:0]          req_operand_b,
   input  logic [W-1:0]                             modulus,
   output mau_pkg::dp_stat_type                     stat,
   output logic [W-1:0]                             result
);

   localparam int CW = (W > 1) ? $clog2(W) : 1;

   logic [W-1:0]     a_ff, a_in;
   logic [W-1:0]     b_ff, b_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic [W-1:0]     out_ff, out_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             bypass_ff, bypass_in;
   mau_pkg::cmd_type op_ff, op_in;

   logic [W:0]       m_ext;
   logic [W:0]       diff;
   logic [W-1:0]     sub_res;
   logic [W:0]       shifted;
   logic [W:0]       shifted_red;
   logic [W-1:0]     rem_nxt;
   logic             last;

   // (x + y) mod m for x, y below m, with the sum held at one extra bit.
   function automatic logic [W-1:0] mod_sum(input logic [W-1:0] x,
                                            input logic [W-1:0] y,
                                            input logic [W:0]   mx);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= mx) begin
         s = s - mx;
      end
      return s[W-1:0];
   endfunction

   // A zero modulus stands for 2^W.
   assign m_ext = {(modulus == '0), modulus};

   assign diff    = {1'b0, a_ff} - {1'b0, b_ff};
   assign sub_res = diff[W-1:0] + (diff[W] ? modulus : '0);

   // One step of restoring division: shift in the next bit of a, MSB first.
   assign shifted     = {rem_ff, a_ff[W-1]};
   assign shifted_red = shifted - m_ext;
   assign rem_nxt     = (shifted >= m_ext) ? shifted_red[W-1:0] : shifted[W-1:0];

   assign last = (cnt_ff == CW'(W - 1));

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      rem_in    = rem_ff;
      acc_in    = acc_ff;
      out_in    = out_ff;
      cnt_in    = cnt_ff;
      bypass_in = bypass_ff;
      op_in     = op_ff;
      if (ctrl.load) begin
         a_in      = req_operand_a[W-1:0];
         b_in      = (req_cmd == mau_pkg::CMD_SQR) ? req_operand_a[W-1:0]
                                                   : req_operand_b[W-1:0];
         op_in     = req_cmd;
         rem_in    = '0;
         acc_in    = '0;
         cnt_in    = '0;
         bypass_in = 1'b0;
      end
      if (ctrl.prep) begin
         // Addition runs as a subtraction of modulus - b, unless b is zero.
         if (op_ff == mau_pkg::CMD_ADD) begin
            bypass_in = (b_ff == '0);
            b_in      = modulus - b_ff;
         end else begin
            bypass_in = 1'b0;
         end
      end
      if (ctrl.sub) begin
         acc_in = bypass_ff ? a_ff : sub_res;
      end
      if (ctrl.reduce) begin
         rem_in = rem_nxt;
         cnt_in = cnt_ff + CW'(1);
         if (last) begin
            a_in   = rem_nxt;
            cnt_in = '0;
         end else begin
            a_in = {a_ff[W-2:0], 1'b0};
         end
      end
      if (ctrl.mul) begin
         if (b_ff[0]) begin
            acc_in = mod_sum(acc_ff, a_ff, m_ext);
         end
         a_in   = mod_sum(a_ff, a_ff, m_ext);
         b_in   = {1'b0, b_ff[W-1:1]};
         cnt_in = cnt_ff + CW'(1);
      end
      if (ctrl.write_out) begin
         out_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      rem_ff    <= rem_in;
      acc_ff    <= acc_in;
      out_ff    <= out_in;
      cnt_ff    <= cnt_in;
      bypass_ff <= bypass_in;
      op_ff     <= op_in;
   end

   assign stat.last_bit = last;
   assign result        = out_ff;

endmodule

// ----- hdl/mau_controller.sv -----
// Controller state machine of the modular arithmetic unit.
module mau_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mau_pkg::cmd_type     req_cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mau_pkg::dp_stat_type stat,
   output mau_pkg::dp_ctrl_type ctrl
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_PREP   = 6'b000010,
      S_SUB    = 6'b000100,
      S_REDUCE = 6'b001000,
      S_MUL    = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               if (req_cmd inside {mau_pkg::CMD_MUL, mau_pkg::CMD_SQR}) begin
                  state_in = S_REDUCE;
               end else begin
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            ctrl.prep = 1'b1;
            state_in  = S_SUB;
         end
         S_SUB: begin
            ctrl.sub = 1'b1;
            state_in = S_FINISH;
         end
         S_REDUCE: begin
            ctrl.reduce = 1'b1;
            if (stat.last_bit) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            ctrl.mul = 1'b1;
            if (stat.last_bit) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // Hold the finished item until the output register is free.
            if (slot_free) begin
               ctrl.write_out = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (ctrl.write_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_addsub_to_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_cmd == mau_pkg::CMD_ADD || req_cmd == mau_pkg::CMD_SUB))
      |=> (state_ff == S_PREP))
      else $error("add or subtract item did not enter the prepare step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.write_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register written while holding an untaken item");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && slot_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished item was not presented on the result channel");

   a_reduce_to_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REDUCE && stat.last_bit) |=> (state_ff == S_MUL))
      else $error("multiply did not follow the end of the reduction");
`endif

endmodule

// ----- hdl/modular_arithmetic_unit.sv -----
// Top level of the modular arithmetic unit: modulus register, controller, datapath.
// Add and subtract run through the prepare, subtract and finish steps once the item is taken.
// Multiply and square run the bit-serial reducer, then the double-and-add adder, then finish.
// A new item is taken only when idle, after the last result is written out.
// Synchronous active-high reset empties the unit and sets the modulus to 1.
module modular_arithmetic_unit #(
   parameter int WORD_WIDTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic [mau_pkg::FIELD_WIDTH-1:0]     req_operand_a,
   input  logic [mau_pkg::FIELD_WIDTH-1:0]     req_operand_b,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mau_pkg::FIELD_WIDTH-1:0]     rsp_result,
   input  logic                                csr_wr_en,
   input  logic [mau_pkg::FIELD_WIDTH-1:0]     csr_wr_data
);

   logic [mau_pkg::FIELD_WIDTH-1:0] modulus_ff, modulus_in;
   mau_pkg::dp_ctrl_type            ctrl;
   mau_pkg::dp_stat_type            stat;
   mau_pkg::cmd_type                cmd;
   logic [WORD_WIDTH-1:0]           result;

   assign cmd        = mau_pkg::cmd_type'(req_cmd);
   assign modulus_in = csr_wr_en ? csr_wr_data : modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mau_pkg::FIELD_WIDTH'(1);
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   mau_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   mau_datapath #(
      .W (WORD_WIDTH)
   ) u_dp (
      .clock         (clock),
      .ctrl          (ctrl),
      .req_cmd       (cmd),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .modulus       (modulus_ff[WORD_WIDTH-1:0]),
      .stat          (stat),
      .result        (result)
   );

   assign rsp_result = mau_pkg::FIELD_WIDTH'(result);

endmodule

// ----- dv/tb_modular_arithmetic_unit.sv -----
// Self-checking testbench for the modular arithmetic unit.
`timescale 1ns / 100ps

typedef logic [mau_pkg::FIELD_WIDTH-1:0] word_type;

class modmath_checker;
   localparam int W = mau_pkg::FIELD_WIDTH;

   word_type    modulus;
   word_type    pending_residues[$];
   int unsigned mismatches;
   int unsigned cmd_seen[4];

   function new();
      modulus = 1;
      mismatches = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
   endfunction

   function void set_modulus(word_type m);
      modulus = m;
   endfunction

   function int unsigned outstanding();
      return pending_residues.size();
   endfunction

   function word_type sub_residue(word_type x, word_type y);
      if (x >= y) return x - y;
      return modulus - y + x;
   endfunction

   function word_type add_residue(word_type x, word_type y);
      if (y == 0) return x;
      return sub_residue(x, modulus - y);
   endfunction

   // The sum carries one extra bit so that a modulus above 2^(W-1) loses nothing.
   function word_type sum_residue(word_type x, word_type y);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, modulus}) s = s - {1'b0, modulus};
      return s[W-1:0];
   endfunction

   function word_type mul_residue(word_type x, word_type y);
      word_type acc;
      word_type run;
      int       i;
      // A zero modulus stands for 2^W, so the product simply wraps.
      if (modulus == 0) return x * y;
      acc = '0;
      run = x % modulus;
      for (i = 0; i < W; i++) begin
         if (y[i]) acc = sum_residue(acc, run);
         run = sum_residue(run, run);
      end
      return acc;
   endfunction

   function word_type predict_residue(mau_pkg::cmd_type cmd, word_type a, word_type b);
      case (cmd)
         mau_pkg::CMD_ADD: return add_residue(a, b);
         mau_pkg::CMD_SUB: return sub_residue(a, b);
         mau_pkg::CMD_MUL: return mul_residue(a, b);
         default:          return mul_residue(a, a);
      endcase
   endfunction

   function void note_request(mau_pkg::cmd_type cmd, word_type a, word_type b);
      cmd_seen[cmd]++;
      pending_residues.push_back(predict_residue(cmd, a, b));
   endfunction

   function void check_result(word_type actual);
      word_type want;
      if (pending_residues.size() == 0) begin
         $error("rsp_result: no item outstanding, expected none, actual %h", actual);
         mismatches++;
         return;
      end
      want = pending_residues.pop_front();
      if (actual !== want) begin
         $error("rsp_result mismatch: expected %h, actual %h", want, actual);
         mismatches++;
      end
   endfunction
endclass

module tb_modular_arithmetic_unit;

   localparam int       STALL_LIMIT   = 2000;
   localparam int       SETTLE_CYCLES = 140;
   localparam int       PHASE_ITEMS   = 180;
   localparam word_type ONES          = '1;
   localparam word_type BIG_PRIME     = 64'hFFFF_FFFF_FFFF_FFC5;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   logic     [1:0] req_cmd = '0;
   word_type req_operand_a = '0;
   word_type req_operand_b = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   word_type rsp_result;
   logic     csr_wr_en = 1'b0;
   word_type csr_wr_data = '0;

   modmath_checker checker_h = new();

   int unsigned results_seen = 0;
   int unsigned results_drawn = 0;
   int unsigned rsp_stall = 0;
   bit          rsp_burst = 1'b0;
   bit          req_burst = 1'b0;
   int unsigned quiet_cycles = 0;
   int unsigned modulus_settings = 1;

   always #5 clock = ~clock;

   modular_arithmetic_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result    (rsp_result),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   // Result monitor and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            checker_h.check_result(rsp_result);
            results_seen++;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles.", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Receiver back-pressure: a fresh stall is drawn after every accepted result.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (results_seen != results_drawn) begin
            results_drawn = results_seen;
            if ($urandom_range(0, 19) == 0) rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 16);
         end
         if (rsp_stall != 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(mau_pkg::cmd_type cmd, word_type a, word_type b);
      int unsigned gap;
      if ($urandom_range(0, 19) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (!req_ready);
      checker_h.note_request(cmd, a, b);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (checker_h.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_modulus(word_type m);
      drain_results();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      checker_h.set_modulus(m);
      modulus_settings++;
   endtask

   function automatic word_type rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic word_type pick_modulus(int kind);
      case (kind)
         0:       return 1;
         1:       return 0;
         2:       return ONES;
         3:       return rand_word() | 64'h8000_0000_0000_0000;
         4:       return $urandom_range(2, 1000);
         5:       return rand_word() | 64'd1;
         6:       return {32'd0, $urandom} | 64'd1;
         7:       return 64'h8000_0000_0000_0000;
         default: return 3;
      endcase
   endfunction

   // Mostly operands already reduced, with edges and unreduced values mixed in.
   function automatic word_type pick_operand(word_type m);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ONES;
         2:       return m - 1;
         3:       return m;
         4, 5:    return rand_word();
         default: return (m == 0) ? rand_word() : rand_word() % m;
      endcase
   endfunction

   initial begin
      word_type m;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Reset modulus of one.
      send_item(mau_pkg::CMD_ADD, ONES, '0);
      send_item(mau_pkg::CMD_SUB, '0, ONES);
      send_item(mau_pkg::CMD_MUL, ONES, ONES);
      send_item(mau_pkg::CMD_SQR, ONES, '0);

      // Modulus above 2^63, where sums carry past the word.
      write_modulus(BIG_PRIME);
      send_item(mau_pkg::CMD_ADD, '0, '0);
      send_item(mau_pkg::CMD_ADD, BIG_PRIME - 1, '0);
      send_item(mau_pkg::CMD_ADD, BIG_PRIME - 1, BIG_PRIME - 1);
      send_item(mau_pkg::CMD_ADD, ONES, ONES);
      send_item(mau_pkg::CMD_SUB, '0, BIG_PRIME - 1);
      send_item(mau_pkg::CMD_SUB, BIG_PRIME - 1, BIG_PRIME - 1);
      send_item(mau_pkg::CMD_SUB, 64'd5, ONES);
      send_item(mau_pkg::CMD_MUL, ONES, ONES);
      send_item(mau_pkg::CMD_MUL, BIG_PRIME - 1, BIG_PRIME - 1);
      send_item(mau_pkg::CMD_MUL, BIG_PRIME, 64'd7);
      send_item(mau_pkg::CMD_MUL, 64'h1234_5678_9ABC_DEF0, '0);
      send_item(mau_pkg::CMD_SQR, BIG_PRIME - 1, ONES);
      send_item(mau_pkg::CMD_SQR, ONES, '0);

      // Zero modulus behaves as 2^64.
      write_modulus('0);
      send_item(mau_pkg::CMD_ADD, ONES, 64'd1);
      send_item(mau_pkg::CMD_SUB, '0, 64'd1);
      send_item(mau_pkg::CMD_MUL, ONES, ONES);
      send_item(mau_pkg::CMD_SQR, 64'h8000_0000_0000_0000, '0);
      send_item(mau_pkg::CMD_MUL, 64'd123, ONES);

      for (int phase = 0; phase < 9; phase++) begin
         m = pick_modulus(phase);
         write_modulus(m);
         repeat (PHASE_ITEMS) begin
            send_item(mau_pkg::cmd_type'($urandom_range(0, 3)),
                      pick_operand(m), pick_operand(m));
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d add, %0d subtract, %0d multiply and %0d square items",
               checker_h.cmd_seen[mau_pkg::CMD_ADD], checker_h.cmd_seen[mau_pkg::CMD_SUB],
               checker_h.cmd_seen[mau_pkg::CMD_MUL], checker_h.cmd_seen[mau_pkg::CMD_SQR]);
      $display("across %0d modulus settings, including zero, one and all ones.",
               modulus_settings);
      if (checker_h.mismatches == 0 && checker_h.outstanding() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/mau_pkg.sv
hdl/mau_datapath.sv
hdl/mau_controller.sv
hdl/modular_arithmetic_unit.sv
dv/tb_modular_arithmetic_unit.sv
